[rtl/iatv_pkg.sv]
`timescale 1ns / 1ps

package iatv_pkg;

    // address byte accounting
    localparam int unsigned BYTES_V6    = 16;
    localparam int unsigned BYTES_V4    = 4;
    localparam int unsigned BYTES_GROUP = 2;
    localparam int unsigned BYTES_W     = 5;

    localparam int unsigned OCTETS_V4   = 4;
    localparam int unsigned OCTET_MAX   = 255;
    localparam int unsigned GROUP_MAX   = 'hffff;

    // character codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT   = 8'h2e;

    // start phase codes
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_COLON  = 2'd1;
    localparam logic [1:0] PH_NORMAL = 2'd2;

    typedef struct packed {
        logic feed;
        logic clear;
    } t_quad_ctl;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] ch);
        t_hex h;
        h.ok  = 1'b1;
        h.nib = 4'd0;
        if (ch inside {[CH_0:CH_9]}) begin
            h.nib = 4'(ch - CH_0);
        end else if (ch inside {[CH_LC_A:CH_LC_F]}) begin
            h.nib = 4'(ch - CH_LC_A + 8'd10);
        end else if (ch inside {[CH_UC_A:CH_UC_F]}) begin
            h.nib = 4'(ch - CH_UC_A + 8'd10);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

[rtl/ip_address_text_validator.sv]
`timescale 1ns / 1ps

// channel  direction  handshake                  payload
// input    in         i_in_valid / o_in_ready    i_char_code[7:0], i_last_char
// output   out        o_out_valid / i_out_ready  o_ipv4_valid, o_ipv6_valid
//
// one character is taken per cycle while o_in_ready is high; the parse state updates in the
// cycle the beat is accepted, and a string's result is written to the output register
// when its last character is accepted.
// reset (synchronous, active low) clears the parse state and the output valid flag.
// the input stalls only while a result sits in the output register and the
// output side does not take it in that cycle.
module ip_address_text_validator
    import iatv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_ipv4_valid,
    output logic       o_ipv6_valid
);

    logic                r_out_valid;
    logic                r_ipv4, r_ipv6;

    logic [1:0]          r_phase, n_phase;
    logic [15:0]         r_group, n_group;
    logic                r_saw, n_saw;
    logic [BYTES_W-1:0]  r_bytes, n_bytes;
    logic                r_dc, n_dc;
    logic                r_failed, n_failed;
    logic                r_dotted, n_dotted;

    logic                w_accept;
    logic                w_do_feed;
    t_hex                w_hex;
    t_quad_ctl           w_whole_ctl, w_tok_ctl;
    logic                w_whole_ok, w_tok_ok;
    logic                w_six_ok;
    logic [BYTES_W-1:0]  w_tp;
    logic                w_tp_bad;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_hex      = hex_decode(i_char_code);

    always_comb begin
        n_phase   = r_phase;
        n_group   = r_group;
        n_saw     = r_saw;
        n_bytes   = r_bytes;
        n_dc      = r_dc;
        n_failed  = r_failed;
        n_dotted  = r_dotted;
        w_do_feed = 1'b0;
        w_tok_ctl = '0;

        if (!r_failed) begin
            case (r_phase)
                PH_FIRST: begin
                    if (i_char_code == CH_COLON) begin
                        n_phase = PH_COLON;
                        if (i_last_char) n_failed = 1'b1;
                    end else begin
                        n_phase   = PH_NORMAL;
                        w_do_feed = 1'b1;
                    end
                end
                PH_COLON: begin
                    // a leading colon must be doubled
                    n_phase = PH_NORMAL;
                    if (i_char_code != CH_COLON) n_failed = 1'b1;
                    else w_do_feed = 1'b1;
                end
                default: begin
                    w_do_feed = 1'b1;
                end
            endcase
        end

        if (w_do_feed) begin
            if (r_dotted) begin
                w_tok_ctl.feed = 1'b1;
            end else if (w_hex.ok) begin
                w_tok_ctl.feed = 1'b1;
                if (r_group > 16'(GROUP_MAX >> 4)) begin
                    n_failed = 1'b1;
                end else begin
                    n_group = {r_group[11:0], w_hex.nib};
                    n_saw   = 1'b1;
                end
            end else if (i_char_code == CH_COLON) begin
                w_tok_ctl.clear = 1'b1;
                if (!r_saw) begin
                    if (r_dc) n_failed = 1'b1;
                    else n_dc = 1'b1;
                end else if (i_last_char) begin
                    n_failed = 1'b1;
                end else if (r_bytes > BYTES_W'(BYTES_V6 - BYTES_GROUP)) begin
                    n_failed = 1'b1;
                end else begin
                    n_bytes = r_bytes + BYTES_W'(BYTES_GROUP);
                    n_saw   = 1'b0;
                    n_group = 16'd0;
                end
            end else if (i_char_code == CH_DOT
                         && r_bytes <= BYTES_W'(BYTES_V6 - BYTES_V4)) begin
                // dotted tail starts; it covers the current group text
                w_tok_ctl.feed = 1'b1;
                n_bytes  = r_bytes + BYTES_W'(BYTES_V4);
                n_saw    = 1'b0;
                n_dotted = 1'b1;
            end else begin
                n_failed = 1'b1;
            end
        end

        w_tok_ctl.feed  = w_tok_ctl.feed && w_accept;
        w_tok_ctl.clear = w_accept && (w_tok_ctl.clear || i_last_char);
    end

    assign w_whole_ctl.feed  = w_accept;
    assign w_whole_ctl.clear = w_accept && i_last_char;

    iatv_quad u_whole (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_whole_ctl),
        .i_ch      (i_char_code),
        .o_ok_next (w_whole_ok)
    );

    iatv_quad u_token (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_tok_ctl),
        .i_ch      (i_char_code),
        .o_ok_next (w_tok_ok)
    );

    // final byte accounting on the post-beat state
    always_comb begin
        w_tp     = n_bytes;
        w_tp_bad = 1'b0;
        if (n_saw) begin
            if (w_tp > BYTES_W'(BYTES_V6 - BYTES_GROUP)) w_tp_bad = 1'b1;
            w_tp = w_tp + BYTES_W'(BYTES_GROUP);
        end
        if (n_dc) begin
            if (w_tp == BYTES_W'(BYTES_V6)) w_tp_bad = 1'b1;
            w_tp = BYTES_W'(BYTES_V6);
        end
        w_six_ok = !n_failed && !(n_dotted && !w_tok_ok) && !w_tp_bad
                   && (w_tp == BYTES_W'(BYTES_V6));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_last_char)) begin
            r_phase  <= PH_FIRST;
            r_group  <= 16'd0;
            r_saw    <= 1'b0;
            r_bytes  <= '0;
            r_dc     <= 1'b0;
            r_failed <= 1'b0;
            r_dotted <= 1'b0;
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_group  <= n_group;
            r_saw    <= n_saw;
            r_bytes  <= n_bytes;
            r_dc     <= n_dc;
            r_failed <= n_failed;
            r_dotted <= n_dotted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && i_last_char) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_last_char) begin
            r_ipv4 <= w_whole_ok;
            r_ipv6 <= w_six_ok;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_ipv4_valid = r_ipv4;
    assign o_ipv6_valid = r_ipv6;

endmodule

[rtl/iatv_quad.sv]
`timescale 1ns / 1ps

// dotted-quad checker, one character per beat
module iatv_quad
    import iatv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_quad_ctl  i_ctl,
    input  logic [7:0] i_ch,
    output logic       o_ok_next
);

    logic [2:0]  r_cnt, n_cnt;
    logic [7:0]  r_val, n_val;
    logic        r_digit, n_digit;
    logic        r_fail, n_fail;
    logic [11:0] w_nv;

    // val * 10 + digit
    assign w_nv = {1'b0, r_val, 3'b000} + {3'b000, r_val, 1'b0} + {4'd0, 8'(i_ch - CH_0)};

    always_comb begin
        n_cnt   = r_cnt;
        n_val   = r_val;
        n_digit = r_digit;
        n_fail  = r_fail;
        if (i_ctl.feed && !r_fail) begin
            if (i_ch inside {[CH_0:CH_9]}) begin
                if (w_nv > 12'(OCTET_MAX)) begin
                    n_fail = 1'b1;
                end else begin
                    n_val = w_nv[7:0];
                    if (!r_digit) begin
                        if (r_cnt >= 3'(OCTETS_V4)) begin
                            n_fail = 1'b1;
                        end else begin
                            n_cnt   = r_cnt + 3'd1;
                            n_digit = 1'b1;
                        end
                    end
                end
            end else if (i_ch == CH_DOT && r_digit) begin
                if (r_cnt >= 3'(OCTETS_V4)) begin
                    n_fail = 1'b1;
                end else begin
                    n_val   = 8'd0;
                    n_digit = 1'b0;
                end
            end else begin
                n_fail = 1'b1;
            end
        end
    end

    assign o_ok_next = !n_fail && (n_cnt == 3'(OCTETS_V4));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_cnt   <= 3'd0;
            r_val   <= 8'd0;
            r_digit <= 1'b0;
            r_fail  <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_val   <= n_val;
            r_digit <= n_digit;
            r_fail  <= n_fail;
        end
    end

endmodule
